### design/zmtc_pkg.sv
// Shared types and constants for the zero-mask tile codec.
package zmtc_pkg;

  localparam int BYTE_W = 8;
  localparam int SUM_W  = 16;

  // Sequencer state codes.
  localparam int STATE_W = 2;
  localparam logic [STATE_W-1:0] S_IN    = 2'd0;  // waiting for an input transfer
  localparam logic [STATE_W-1:0] S_EXP   = 2'd1;  // expand: literal and zero-fill output
  localparam logic [STATE_W-1:0] S_PMASK = 2'd2;  // pack: mask byte output
  localparam logic [STATE_W-1:0] S_PLIT  = 2'd3;  // pack: literal scan through the tile RAM

  // One result item as it sits in the output register.
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic              done;
    logic              last;
    logic [BYTE_W-1:0] data;
  } out_item_t;

endpackage

### design/zmtc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module zmtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/zero_mask_tile_codec.sv
// Top level of the zero-mask tile codec: expand and pack of byte tiles with bitmask headers.
//
// The codec handles tiles of TILE_BYTES bytes, coded with one mask bit per byte, the
// mask bytes taken most significant bit first. In expand mode (pack_mode = 0) the first
// ceil(TILE_BYTES/8) input bytes of a tile are masks; a set bit takes the next input byte
// as a literal, a clear bit produces a zero byte. Every tile byte is sent as soon as it is
// known, together with the running 16-bit sum of the literals of the tile. In pack mode
// (pack_mode = 1) the raw bytes are written into a tile RAM while the mask is built; after
// the last byte of the tile the block sends the mask bytes and then the nonzero bytes in
// order, with a zero sum. m_tlast marks the last result caused by one input transfer and
// m_tuser the last result of a tile. The block works on one input item at a time. An
// expand mask byte is taken and then the zero bytes it settles are sent one by one; an
// expand literal is sent and then the zero bytes after it. A pack raw byte is stored in
// the tile RAM; after the final byte of a tile the block sends the mask bytes and then
// scans the tile RAM up to the last nonzero byte, where each nonzero byte waits for the
// registered read of the RAM. A stalled output holds back the next result. A result
// waiting in the output register does not hold off the next input transfer. Writing
// the configuration register aborts the current tile; write it only while the block
// is idle.
module zero_mask_tile_codec #(
  parameter int TILE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration register pack_mode.
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] byte_sum
  output logic        m_tlast,   // run_last
  output logic        m_tuser    // [0] tile_done
);

  // Number of mask bytes in a tile header and the width of the mask vector.
  localparam int HDR = (TILE_BYTES + 7) / 8;
  localparam int MW  = HDR * 8;
  localparam int AW  = $clog2(TILE_BYTES);
  localparam int IW  = $clog2(MW);
  localparam int PW  = $clog2(TILE_BYTES + 1);
  localparam int HW  = $clog2(HDR + 1);

  localparam logic [PW-1:0] TILE_POS = PW'(TILE_BYTES);
  localparam logic [HW-1:0] HDR_CNT  = HW'(HDR);
  localparam logic [HW-1:0] HDR_LAST = HW'(HDR - 1);

  // Mask bit p governs tile byte p; header byte h carries bits 8h..8h+7, MSB first.
  logic                          pack_mode, pack_mode_next;
  logic [zmtc_pkg::STATE_W-1:0]  state, state_next;
  logic [HW-1:0]                 header_count, header_count_next;
  logic [MW-1:0]                 mask_bits, mask_bits_next;
  logic [PW-1:0]                 pos, pos_next;
  logic [PW-1:0]                 known, known_next;
  logic [zmtc_pkg::SUM_W-1:0]    literal_sum, literal_sum_next;
  logic                          lit_pending, lit_pending_next;
  logic [zmtc_pkg::BYTE_W-1:0]   lit_byte, lit_byte_next;
  logic                          rd_ok, rd_ok_next;
  zmtc_pkg::out_item_t           out_item, o_item;
  logic                          o_load;
  logic                          clear_tile;

  logic                          can_load;
  logic [PW-1:0]                 pos1;
  logic                          fill_now;
  logic                          fill_after;
  logic [zmtc_pkg::BYTE_W-1:0]   mask_byte;
  logic [MW-1:0]                 mask_rest;

  logic                          ram_we;
  logic [zmtc_pkg::BYTE_W-1:0]   ram_rdata;

  assign s_tready = (state == zmtc_pkg::S_IN);
  assign can_load = !m_tvalid || m_tready;
  assign pos1     = pos + 1'b1;

  // Expand: is a byte owed at the current position, and would one be owed after it.
  assign fill_now   = lit_pending || ((pos < known) && !mask_bits[pos[IW-1:0]]);
  assign fill_after = (pos1 < known) && !mask_bits[pos1[IW-1:0]];

  // Pack: set bits above the current position tell whether more literals follow.
  assign mask_rest = mask_bits >> pos1;

  // Pack: header byte selected by header_count, first tile byte in bit 7.
  always_comb begin
    mask_byte = '0;
    for (int i = 0; i < MW; i++) begin
      if (int'(header_count) == i / 8) begin
        mask_byte[7 - (i % 8)] = mask_bits[i];
      end
    end
  end

  // The tile RAM holds raw bytes in pack mode; it is read at the scan position.
  zmtc_ram #(
    .WIDTH(zmtc_pkg::BYTE_W),
    .DEPTH(TILE_BYTES)
  ) u_tile_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(pos[AW-1:0]),
    .wr_data(s_tdata),
    .rd_addr(pos[AW-1:0]),
    .rd_data(ram_rdata)
  );

  always_comb begin
    int kv;
    pack_mode_next    = pack_mode;
    state_next        = state;
    header_count_next = header_count;
    mask_bits_next    = mask_bits;
    pos_next          = pos;
    known_next        = known;
    literal_sum_next  = literal_sum;
    lit_pending_next  = lit_pending;
    lit_byte_next     = lit_byte;
    rd_ok_next        = 1'b0;
    ram_we            = 1'b0;
    o_load            = 1'b0;
    o_item            = '0;
    clear_tile        = 1'b0;
    kv                = (int'(header_count) + 1) * 8;
    if (kv > TILE_BYTES) begin
      kv = TILE_BYTES;
    end

    case (state)
      zmtc_pkg::S_IN: begin
        if (s_tvalid) begin
          if (pack_mode) begin
            // Store the raw byte and note whether it is nonzero.
            ram_we                          = 1'b1;
            mask_bits_next[pos[IW-1:0]]     = (s_tdata != '0);
            pos_next                        = pos1;
            if (pos1 >= TILE_POS) begin
              header_count_next = '0;
              state_next        = zmtc_pkg::S_PMASK;
            end
          end else if (header_count < HDR_CNT) begin
            // Mask byte: unpack its bits, then settle the zero bytes it governs.
            for (int i = 0; i < MW; i++) begin
              if (int'(header_count) == i / 8) begin
                mask_bits_next[i] = s_tdata[7 - (i % 8)];
              end
            end
            header_count_next = header_count + 1'b1;
            known_next        = PW'(kv);
            lit_pending_next  = 1'b0;
            state_next        = zmtc_pkg::S_EXP;
          end else begin
            // Literal byte: it is sent first, zero bytes up to the next set bit follow.
            literal_sum_next = literal_sum + {8'b0, s_tdata};
            lit_byte_next    = s_tdata;
            lit_pending_next = 1'b1;
            known_next       = TILE_POS;
            state_next       = zmtc_pkg::S_EXP;
          end
        end
      end

      zmtc_pkg::S_EXP: begin
        if (!fill_now) begin
          state_next = zmtc_pkg::S_IN;
        end else if (can_load) begin
          o_load           = 1'b1;
          o_item.data      = lit_pending ? lit_byte : '0;
          o_item.sum       = literal_sum;
          lit_pending_next = 1'b0;
          pos_next         = pos1;
          if (!fill_after) begin
            o_item.last = 1'b1;
            state_next  = zmtc_pkg::S_IN;
            if (pos1 >= TILE_POS) begin
              o_item.done = 1'b1;
              clear_tile  = 1'b1;
            end
          end
        end
      end

      zmtc_pkg::S_PMASK: begin
        if (can_load) begin
          o_load      = 1'b1;
          o_item.data = mask_byte;
          if (header_count == HDR_LAST) begin
            if (mask_bits == '0) begin
              // A tile of zeros ends with its last mask byte.
              o_item.last = 1'b1;
              o_item.done = 1'b1;
              clear_tile  = 1'b1;
              state_next  = zmtc_pkg::S_IN;
            end else begin
              pos_next   = '0;
              state_next = zmtc_pkg::S_PLIT;
            end
          end else begin
            header_count_next = header_count + 1'b1;
          end
        end
      end

      zmtc_pkg::S_PLIT: begin
        // rd_ok says the RAM output belongs to the current position.
        rd_ok_next = 1'b1;
        if (!mask_bits[pos[IW-1:0]]) begin
          pos_next   = pos1;
          rd_ok_next = 1'b0;
        end else if (rd_ok && can_load) begin
          o_load      = 1'b1;
          o_item.data = ram_rdata;
          if (mask_rest == '0) begin
            o_item.last = 1'b1;
            o_item.done = 1'b1;
            clear_tile  = 1'b1;
            state_next  = zmtc_pkg::S_IN;
          end else begin
            pos_next   = pos1;
            rd_ok_next = 1'b0;
          end
        end
      end

      default: begin
        state_next = zmtc_pkg::S_IN;
      end
    endcase

    // A mode write restarts the tile from scratch.
    if (cfg_wen) begin
      pack_mode_next = cfg_wdata;
      clear_tile     = 1'b1;
      state_next     = zmtc_pkg::S_IN;
    end

    if (clear_tile) begin
      header_count_next = '0;
      mask_bits_next    = '0;
      pos_next          = '0;
      known_next        = '0;
      literal_sum_next  = '0;
      lit_pending_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_mode    <= 1'b0;
      state        <= zmtc_pkg::S_IN;
      header_count <= '0;
      mask_bits    <= '0;
      pos          <= '0;
      known        <= '0;
      literal_sum  <= '0;
      lit_pending  <= 1'b0;
      rd_ok        <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      pack_mode    <= pack_mode_next;
      state        <= state_next;
      header_count <= header_count_next;
      mask_bits    <= mask_bits_next;
      pos          <= pos_next;
      known        <= known_next;
      literal_sum  <= literal_sum_next;
      lit_pending  <= lit_pending_next;
      rd_ok        <= rd_ok_next;
      if (o_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    lit_byte <= lit_byte_next;
    if (o_load) begin
      out_item <= o_item;
    end
  end

  assign m_tdata = {out_item.sum, out_item.data};
  assign m_tlast = out_item.last;
  assign m_tuser = out_item.done;

endmodule
